### hw/rtl/utf16_to_utf8_encoder_defines.svh
// Assertion macros for the UTF-16 to UTF-8 encoder.
// Each one samples on the rising edge of clock and is muted while reset is high.
`ifndef UTF16_TO_UTF8_ENCODER_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define U16U8_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/u16u8_pkg.sv
package u16u8_pkg;

   // Most bytes one request can produce: a flushed high surrogate plus a 3-byte unit
   localparam int unsigned MaxBytes          = 6;
   localparam int unsigned CountWidth        = $clog2(MaxBytes + 1);
   localparam int unsigned QueueDepthDefault = 2;

   // Classification masks and tags
   localparam logic [15:0] MaskAscii = 16'hFF80;
   localparam logic [15:0] MaskTwo   = 16'hF800;
   localparam logic [15:0] MaskSurr  = 16'hFC00;
   localparam logic [15:0] HighTag   = 16'hD800;
   localparam logic [15:0] LowTag    = 16'hDC00;

   // UTF-8 lead and continuation prefixes
   localparam logic [7:0] Lead4   = 8'hF0;
   localparam logic [7:0] Lead3   = 8'hE0;
   localparam logic [7:0] Lead2   = 8'hC0;
   localparam logic [7:0] ContTag = 8'h80;

   // One classified request: bytes in send order from index 0
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [CountWidth-1:0]    count;
      logic                     eos;
   } job_type;

endpackage

### hw/rtl/u16u8_front.sv
module u16u8_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [15:0]       req_code_unit,
   input  logic              q_not_full,
   output logic              q_push,
   output u16u8_pkg::job_type q_job
);
   import u16u8_pkg::*;

   logic        pending_ff, pending_in;
   logic [15:0] held_ff, held_in;

   logic                  accept;
   logic                  is_high, is_low;
   logic [2:0][7:0]       cur_bytes;
   logic [CountWidth-1:0] cur_count;
   logic                  cur_eos;
   logic [20:0]           cp;
   job_type               job;

   function automatic logic [2:0][7:0] three_form(input logic [15:0] u);
      logic [2:0][7:0] b;
      b[0] = Lead3   | {4'b0, u[15:12]};
      b[1] = ContTag | {2'b0, u[11:6]};
      b[2] = ContTag | {2'b0, u[5:0]};
      return b;
   endfunction

   always_comb begin
      accept  = req_valid && q_not_full;
      is_high = (req_code_unit & MaskSurr) == HighTag;
      is_low  = (req_code_unit & MaskSurr) == LowTag;
      cp      = 21'h10000 + {1'b0, held_ff[9:0], req_code_unit[9:0]};

      // classify the current unit as if nothing were held
      cur_bytes = '0;
      cur_count = '0;
      cur_eos   = 1'b0;
      if (req_code_unit == 16'h0000) begin
         cur_count = CountWidth'(1);
         cur_eos   = 1'b1;
      end else if (is_high) begin
         cur_count = '0;
      end else if ((req_code_unit & MaskAscii) == 16'h0000) begin
         cur_bytes[0] = req_code_unit[7:0];
         cur_count    = CountWidth'(1);
      end else if ((req_code_unit & MaskTwo) == 16'h0000) begin
         cur_bytes[0] = Lead2   | {3'b0, req_code_unit[10:6]};
         cur_bytes[1] = ContTag | {2'b0, req_code_unit[5:0]};
         cur_count    = CountWidth'(2);
      end else begin
         cur_bytes = three_form(req_code_unit);
         cur_count = CountWidth'(3);
      end

      job = '0;
      if (pending_ff && is_low) begin
         job.bytes[0] = Lead4   | {5'b0, cp[20:18]};
         job.bytes[1] = ContTag | {2'b0, cp[17:12]};
         job.bytes[2] = ContTag | {2'b0, cp[11:6]};
         job.bytes[3] = ContTag | {2'b0, cp[5:0]};
         job.count    = CountWidth'(4);
      end else if (pending_ff) begin
         // flush the held unit ahead of the current one
         job.bytes[2:0] = three_form(held_ff);
         for (int i = 0; i < 3; i++) begin
            job.bytes[i+3] = cur_bytes[i];
         end
         job.count = CountWidth'(3) + cur_count;
         job.eos   = cur_eos;
      end else begin
         job.bytes[2:0] = cur_bytes;
         job.count      = cur_count;
         job.eos        = cur_eos;
      end

      pending_in = pending_ff;
      held_in    = held_ff;
      if (accept) begin
         pending_in = is_high;
         if (is_high) begin
            held_in = req_code_unit;
         end
      end

      req_ready = q_not_full;
      q_push    = accept && (job.count != '0);
      q_job     = job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

endmodule

### hw/rtl/u16u8_queue.sv
module u16u8_queue #(
   parameter int unsigned Depth = u16u8_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u16u8_pkg::job_type push_job,
   input  logic               pop,
   output logic               not_full,
   output logic               not_empty,
   output u16u8_pkg::job_type head_job
);
   import u16u8_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   job_type               mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   function automatic logic [PtrWidth-1:0] bump(input logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(Depth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      not_full  = count_ff != CntWidth'(Depth);
      not_empty = count_ff != '0;
      head_job  = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### hw/rtl/u16u8_back.sv
module u16u8_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  u16u8_pkg::job_type q_job,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_of_run,
   output logic               rsp_end_of_string
);
   import u16u8_pkg::*;

   localparam int unsigned IdxWidth = $clog2(MaxBytes);

   job_type             job_ff, job_in;
   logic                busy_ff, busy_in;
   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                last_ff, last_in;
   logic                eos_ff, eos_in;

   logic out_free, is_last, emit, load;

   always_comb begin
      out_free = !valid_ff || rsp_ready;
      is_last  = CountWidth'(idx_ff) + CountWidth'(1) == job_ff.count;
      emit     = busy_ff && out_free;
      // take the next job as the current one sends its final byte
      load     = q_not_empty && (!busy_ff || (emit && is_last));

      job_in  = load ? q_job : job_ff;
      busy_in = busy_ff;
      if (load) begin
         busy_in = 1'b1;
      end else if (emit && is_last) begin
         busy_in = 1'b0;
      end
      idx_in = idx_ff;
      if (load) begin
         idx_in = '0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end

      valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      byte_in  = emit ? job_ff.bytes[idx_ff] : byte_ff;
      last_in  = emit ? is_last : last_ff;
      eos_in   = emit ? (is_last && job_ff.eos) : eos_ff;

      q_pop             = load;
      rsp_valid         = valid_ff;
      rsp_out_byte      = byte_ff;
      rsp_last_of_run   = last_ff;
      rsp_end_of_string = eos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      eos_ff  <= eos_in;
   end

endmodule

### hw/rtl/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 stream encoder. Each request carries one UTF-16 code unit, and the
// response channel returns the UTF-8 bytes one per transfer, with last_of_run on the final
// byte of each request and end_of_string on the zero terminator. A high surrogate is held
// without output until the next unit: a following low surrogate makes the 4-byte form,
// anything else first flushes the held unit as 3 bytes. A zero unit flushes, then sends the
// terminator. The front end accepts one request per cycle while the job queue (QueueDepth
// entries) has room; the byte serialiser then sends the bytes one at a time: 1 to 3 bytes for
// a plain unit, 4 for a surrogate pair, up to 6 when a flush precedes a 3-byte unit, and
// none for a high surrogate that is only held. Sustained throughput is thus set by the
// output serialiser at one byte per cycle while rsp_ready is high. The first byte passes
// through the job queue, the serialiser's job register and its output register.
`include "utf16_to_utf8_encoder_defines.svh"

module utf16_to_utf8_encoder #(
   parameter int unsigned QueueDepth = u16u8_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_end_of_string
);
   import u16u8_pkg::*;

   // front end to queue
   logic    q_push;
   job_type q_push_job;
   logic    q_not_full;
   // queue to serialiser
   logic    q_pop;
   logic    q_not_empty;
   job_type q_head_job;

   // classify each request and track the held surrogate
   u16u8_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_unit (req_code_unit),
      .q_not_full    (q_not_full),
      .q_push        (q_push),
      .q_job         (q_push_job)
   );

   // hold classified jobs so either side can stall on its own
   u16u8_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .pop       (q_pop),
      .not_full  (q_not_full),
      .not_empty (q_not_empty),
      .head_job  (q_head_job)
   );

   // send the bytes of each job through a registered output stage
   u16u8_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_not_empty       (q_not_empty),
      .q_job             (q_head_job),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_string (rsp_end_of_string)
   );

   // terminator always closes its request's run and is a zero byte
   `U16U8_ASSERT_NOW(a_eos_is_last, rsp_valid && rsp_end_of_string, rsp_last_of_run, "terminator not last of run")
   `U16U8_ASSERT_NOW(a_eos_is_zero, rsp_valid && rsp_end_of_string, rsp_out_byte == 8'h00, "terminator byte not zero")
   // a 4-byte lead byte is always followed by continuation bytes of the same request
   `U16U8_ASSERT_NOW(a_lead4_not_last, rsp_valid && (rsp_out_byte[7:3] == 5'b11110), !rsp_last_of_run, "4-byte lead ends run")
   // a request that produced bytes reaches the queue
   `U16U8_ASSERT_NEXT(a_push_fills, q_push && !q_pop, q_not_empty, "queue empty after push")

endmodule
